// ===== design/bee_pkg.sv =====
// ----------------------------------------------------------------------------
// bee_pkg: shared types and constants of the expression evaluator
// Character codes, status and operator codes, the job record that moves
// from the parser to the execution unit, and the output sizing helper.
// ----------------------------------------------------------------------------
package bee_pkg;

    // operand width; values wrap at this many bits
    localparam int VALUE_BITS = 32;
    localparam int OUT_BITS   = 32;
    localparam int CNT_BITS   = $clog2(VALUE_BITS);

    // line queue between parser and execution unit
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // character codes
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_STAR  = 8'd42;
    localparam logic [7:0] CH_SLASH = 8'd47;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LOW_Q = 8'd113;
    localparam logic [7:0] CH_UP_Q  = 8'd81;
    localparam logic [7:0] DEC_BASE = 8'd10;

    // result status
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;
    localparam logic [1:0] ST_QUIT = 2'd3;

    // operators
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // one parsed line: magnitudes and signs as they came off the parser
    typedef struct packed {
        logic [1:0]            status;
        logic [1:0]            op;
        logic                  a_neg;
        logic [VALUE_BITS-1:0] a_mag;
        logic                  b_neg;
        logic [VALUE_BITS-1:0] b_mag;
    } t_job;

    // sign-extend or truncate a wrapped value to the output width
    function automatic logic [OUT_BITS-1:0] to_out(input logic [VALUE_BITS-1:0] v);
        logic [VALUE_BITS+OUT_BITS-1:0] ext;
        ext = {{OUT_BITS{v[VALUE_BITS-1]}}, v};
        return ext[OUT_BITS-1:0];
    endfunction

endpackage

// ===== design/bee_front.sv =====
// ----------------------------------------------------------------------------
// bee_front: character parser
// Takes one character per transaction, tracks the parse phase and the
// operand accumulators, and pushes one job per line on the last character.
// ----------------------------------------------------------------------------
module bee_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_ch,
    input  logic                i_last,
    output logic                o_job_valid,
    input  logic                i_job_ready,
    output bee_pkg::t_job       o_job
);

    typedef enum logic [3:0] {
        P_LEAD1, P_SIGN1, P_DIG1, P_PREOP, P_LEAD2, P_SIGN2, P_DIG2, P_TRAIL, P_ERR
    } t_phase;

    t_phase                           r_phase, n_phase;
    logic [bee_pkg::VALUE_BITS-1:0]   r_acc1, n_acc1, r_acc2, n_acc2;
    logic                             r_neg1, n_neg1, r_neg2, n_neg2;
    logic [1:0]                       r_op, n_op;
    logic                             r_seen;

    logic                             is_blank, is_numeral, is_op, is_quit, accept;
    logic [1:0]                       op_idx;
    logic [7:0]                       dval;
    logic [bee_pkg::VALUE_BITS-1:0]   dig1, dig2;

    assign accept     = i_valid && o_ready;
    assign o_ready    = i_job_ready;
    assign is_blank   = (i_ch == bee_pkg::CH_SPACE) || (i_ch == bee_pkg::CH_TAB);
    assign is_numeral = (i_ch >= bee_pkg::CH_ZERO) && (i_ch <= bee_pkg::CH_NINE);
    assign is_quit    = (i_ch == bee_pkg::CH_LOW_Q) || (i_ch == bee_pkg::CH_UP_Q);
    assign dval       = i_ch - bee_pkg::CH_ZERO;

    // acc * 10 + digit, as two shifts and two adds
    assign dig1 = (r_acc1 << 3) + (r_acc1 << 1) + bee_pkg::VALUE_BITS'(dval);
    assign dig2 = (r_acc2 << 3) + (r_acc2 << 1) + bee_pkg::VALUE_BITS'(dval);

    always_comb begin
        is_op  = 1'b1;
        op_idx = bee_pkg::OP_ADD;
        case (i_ch)
            bee_pkg::CH_PLUS:  op_idx = bee_pkg::OP_ADD;
            bee_pkg::CH_MINUS: op_idx = bee_pkg::OP_SUB;
            bee_pkg::CH_STAR:  op_idx = bee_pkg::OP_MUL;
            bee_pkg::CH_SLASH: op_idx = bee_pkg::OP_DIV;
            default:           is_op  = 1'b0;
        endcase
    end

    always_comb begin
        n_phase = r_phase;
        n_acc1  = r_acc1;
        n_acc2  = r_acc2;
        n_neg1  = r_neg1;
        n_neg2  = r_neg2;
        n_op    = r_op;
        unique case (r_phase)
            P_LEAD1: begin
                if (is_blank) n_phase = P_LEAD1;
                else if (i_ch == bee_pkg::CH_PLUS) n_phase = P_SIGN1;
                else if (i_ch == bee_pkg::CH_MINUS) begin
                    n_neg1  = 1'b1;
                    n_phase = P_SIGN1;
                end else if (is_numeral) begin
                    n_acc1  = dig1;
                    n_phase = P_DIG1;
                end else n_phase = P_ERR;
            end
            P_SIGN1: begin
                if (is_numeral) begin
                    n_acc1  = dig1;
                    n_phase = P_DIG1;
                end else n_phase = P_ERR;
            end
            P_DIG1: begin
                if (is_numeral) n_acc1 = dig1;
                else if (is_blank) n_phase = P_PREOP;
                else if (is_op) begin
                    n_op    = op_idx;
                    n_phase = P_LEAD2;
                end else n_phase = P_ERR;
            end
            P_PREOP: begin
                if (is_blank) n_phase = P_PREOP;
                else if (is_op) begin
                    n_op    = op_idx;
                    n_phase = P_LEAD2;
                end else n_phase = P_ERR;
            end
            P_LEAD2: begin
                if (is_blank) n_phase = P_LEAD2;
                else if (i_ch == bee_pkg::CH_PLUS) n_phase = P_SIGN2;
                else if (i_ch == bee_pkg::CH_MINUS) begin
                    n_neg2  = 1'b1;
                    n_phase = P_SIGN2;
                end else if (is_numeral) begin
                    n_acc2  = dig2;
                    n_phase = P_DIG2;
                end else n_phase = P_ERR;
            end
            P_SIGN2: begin
                if (is_numeral) begin
                    n_acc2  = dig2;
                    n_phase = P_DIG2;
                end else n_phase = P_ERR;
            end
            P_DIG2: begin
                if (is_numeral) n_acc2 = dig2;
                else if (is_blank) n_phase = P_TRAIL;
                else n_phase = P_ERR;
            end
            P_TRAIL: begin
                if (!is_blank) n_phase = P_ERR;
            end
            default: n_phase = P_ERR;
        endcase
    end

    // job for the queue, built from the post-character state
    always_comb begin
        o_job_valid  = accept && i_last;
        o_job.op     = n_op;
        o_job.a_neg  = n_neg1;
        o_job.a_mag  = n_acc1;
        o_job.b_neg  = n_neg2;
        o_job.b_mag  = n_acc2;
        if (!r_seen && is_quit) o_job.status = bee_pkg::ST_QUIT;
        else if (n_phase != P_DIG2 && n_phase != P_TRAIL) o_job.status = bee_pkg::ST_BAD;
        else o_job.status = bee_pkg::ST_OK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_LEAD1;
            r_acc1  <= '0;
            r_acc2  <= '0;
            r_neg1  <= 1'b0;
            r_neg2  <= 1'b0;
            r_op    <= bee_pkg::OP_ADD;
            r_seen  <= 1'b0;
        end else if (accept) begin
            if (i_last) begin
                r_phase <= P_LEAD1;
                r_acc1  <= '0;
                r_acc2  <= '0;
                r_neg1  <= 1'b0;
                r_neg2  <= 1'b0;
                r_op    <= bee_pkg::OP_ADD;
                r_seen  <= 1'b0;
            end else begin
                r_phase <= n_phase;
                r_acc1  <= n_acc1;
                r_acc2  <= n_acc2;
                r_neg1  <= n_neg1;
                r_neg2  <= n_neg2;
                r_op    <= n_op;
                r_seen  <= 1'b1;
            end
        end
    end

endmodule

// ===== design/bee_queue.sv =====
// ----------------------------------------------------------------------------
// bee_queue: line job queue
// Small register FIFO that decouples the parser from the execution unit.
// ----------------------------------------------------------------------------
module bee_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_push_ready,
    input  bee_pkg::t_job   i_job,
    output logic            o_pop_valid,
    input  logic            i_pop,
    output bee_pkg::t_job   o_job
);

    bee_pkg::t_job                  r_mem [bee_pkg::QUEUE_DEPTH];
    logic [bee_pkg::QPTR_BITS-1:0]  r_wptr, r_rptr;
    logic [bee_pkg::QCNT_BITS-1:0]  r_count;
    logic                           do_push, do_pop;

    assign o_push_ready = (r_count != bee_pkg::QCNT_BITS'(bee_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;
    assign o_job        = r_mem[r_rptr];

    function automatic logic [bee_pkg::QPTR_BITS-1:0] bump(
        input logic [bee_pkg::QPTR_BITS-1:0] p);
        if (p == bee_pkg::QPTR_BITS'(bee_pkg::QUEUE_DEPTH - 1)) return '0;
        return p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wptr] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wptr <= bump(r_wptr);
            if (do_pop)  r_rptr <= bump(r_rptr);
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // the parser must hold off when the queue is full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_push_ready)
        else $error("job pushed into a full queue");

endmodule

// ===== design/bee_back.sv =====
// ----------------------------------------------------------------------------
// bee_back: execution unit
// Pops one line job, applies signs, evaluates with a shift-add multiplier
// or a restoring divider, and holds the result until it is taken.
// ----------------------------------------------------------------------------
module bee_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_job_valid,
    output logic                                o_job_ready,
    input  bee_pkg::t_job                       i_job,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [1:0]                          o_status,
    output logic signed [bee_pkg::OUT_BITS-1:0] o_left_value,
    output logic [1:0]                          o_operator,
    output logic signed [bee_pkg::OUT_BITS-1:0] o_right_value,
    output logic signed [bee_pkg::OUT_BITS-1:0] o_result_value
);

    typedef enum logic [2:0] {S_IDLE, S_LOAD, S_MUL, S_DIV, S_FIX, S_OUT} t_state;

    t_state                         r_state;
    logic [1:0]                     r_status, r_op;
    logic [bee_pkg::VALUE_BITS-1:0] r_a, r_b, r_res, r_x, r_y, r_rem;
    logic                           r_qneg;
    logic [bee_pkg::CNT_BITS-1:0]   r_cnt;

    logic [bee_pkg::VALUE_BITS-1:0] trial, abs_a, abs_b;
    logic                           fit, cnt_done;

    assign o_job_ready    = (r_state == S_IDLE);
    assign o_valid        = (r_state == S_OUT);
    assign o_status       = r_status;
    assign o_operator     = r_op;
    assign o_left_value   = bee_pkg::to_out(r_a);
    assign o_right_value  = bee_pkg::to_out(r_b);
    assign o_result_value = bee_pkg::to_out(r_res);

    assign abs_a    = r_a[bee_pkg::VALUE_BITS-1] ? (bee_pkg::VALUE_BITS'(0) - r_a) : r_a;
    assign abs_b    = r_b[bee_pkg::VALUE_BITS-1] ? (bee_pkg::VALUE_BITS'(0) - r_b) : r_b;
    assign trial    = {r_rem[bee_pkg::VALUE_BITS-2:0], r_x[bee_pkg::VALUE_BITS-1]};
    assign fit      = (trial >= r_y);
    assign cnt_done = (r_cnt == bee_pkg::CNT_BITS'(bee_pkg::VALUE_BITS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_status <= i_job.status;
                        r_op     <= i_job.op;
                        r_a      <= i_job.a_neg ?
                                    (bee_pkg::VALUE_BITS'(0) - i_job.a_mag) : i_job.a_mag;
                        r_b      <= i_job.b_neg ?
                                    (bee_pkg::VALUE_BITS'(0) - i_job.b_mag) : i_job.b_mag;
                        r_state  <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_cnt <= '0;
                    if (r_status != bee_pkg::ST_OK) begin
                        r_a     <= '0;
                        r_b     <= '0;
                        r_op    <= bee_pkg::OP_ADD;
                        r_res   <= '0;
                        r_state <= S_OUT;
                    end else begin
                        unique case (r_op)
                            bee_pkg::OP_ADD: begin
                                r_res   <= r_a + r_b;
                                r_state <= S_OUT;
                            end
                            bee_pkg::OP_SUB: begin
                                r_res   <= r_a - r_b;
                                r_state <= S_OUT;
                            end
                            bee_pkg::OP_MUL: begin
                                r_res   <= '0;
                                r_x     <= r_a;
                                r_y     <= r_b;
                                r_state <= S_MUL;
                            end
                            default: begin
                                if (r_b == '0) begin
                                    r_status <= bee_pkg::ST_DIVZ;
                                    r_res    <= '0;
                                    r_state  <= S_OUT;
                                end else begin
                                    r_x     <= abs_a;
                                    r_y     <= abs_b;
                                    r_rem   <= '0;
                                    r_qneg  <= r_a[bee_pkg::VALUE_BITS-1] ^
                                               r_b[bee_pkg::VALUE_BITS-1];
                                    r_state <= S_DIV;
                                end
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    if (r_y[0]) r_res <= r_res + r_x;
                    r_x   <= r_x << 1;
                    r_y   <= r_y >> 1;
                    r_cnt <= r_cnt + 1'b1;
                    if (cnt_done) r_state <= S_OUT;
                end
                S_DIV: begin
                    // one quotient bit per cycle, shifted into r_x
                    r_rem <= fit ? (trial - r_y) : trial;
                    r_x   <= {r_x[bee_pkg::VALUE_BITS-2:0], fit};
                    r_cnt <= r_cnt + 1'b1;
                    if (cnt_done) r_state <= S_FIX;
                end
                S_FIX: begin
                    r_res   <= r_qneg ? (bee_pkg::VALUE_BITS'(0) - r_x) : r_x;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == bee_pkg::ST_BAD || o_status == bee_pkg::ST_QUIT)) |->
        (r_a == '0 && r_b == '0 && r_res == '0 && r_op == bee_pkg::OP_ADD))
        else $error("failed line carries nonzero fields");

    a_divz_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == bee_pkg::ST_DIVZ) |->
        (r_op == bee_pkg::OP_DIV && r_b == '0 && r_res == '0))
        else $error("divide by zero result inconsistent");

    a_add_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == bee_pkg::ST_OK && r_op == bee_pkg::OP_ADD) |->
        (r_res == r_a + r_b))
        else $error("add result mismatch");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> ($past(r_state) == S_IDLE))
        else $error("job loaded outside idle");

endmodule

// ===== design/binary_expression_evaluator_unit.sv =====
// ----------------------------------------------------------------------------
// binary_expression_evaluator_unit: streaming "a op b" line evaluator
// Parses one text line a character at a time and returns one result per line.
// ----------------------------------------------------------------------------
// The parser takes one character per cycle whenever the line queue has room.
// Each line's last character pushes a job into a two-entry queue; the
// execution unit then pops the job, loads it and registers the result for
// add, subtract, bad format, quit and divide by zero; for multiply it runs
// one shift-add step per cycle between load and result, and for divide one
// restoring step per cycle followed by the sign fix; it holds the result
// until the output transaction completes.
// Status is 0 ok, 1 bad format, 2 divide by zero, 3 quit (a line that is
// just q or Q); on bad format and quit all other fields read zero, on divide
// by zero the result and the right operand read zero. Arithmetic wraps at
// VALUE_BITS bits, and division truncates toward zero.
module binary_expression_evaluator_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // character channel
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [7:0]                          i_ch,
    input  logic                                i_last,
    // result channel
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [1:0]                          o_status,
    output logic signed [bee_pkg::OUT_BITS-1:0] o_left_value,
    output logic [1:0]                          o_operator,
    output logic signed [bee_pkg::OUT_BITS-1:0] o_right_value,
    output logic signed [bee_pkg::OUT_BITS-1:0] o_result_value
);

    // parser -> queue
    logic          push, push_ready;
    bee_pkg::t_job push_job;
    // queue -> execution unit
    logic          pop_valid, pop;
    bee_pkg::t_job pop_job;

    // front: classify characters, build one job per line
    bee_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_ch        (i_ch),
        .i_last      (i_last),
        .o_job_valid (push),
        .i_job_ready (push_ready),
        .o_job       (push_job)
    );

    // queue: lets the parser keep taking characters while a divide runs
    bee_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .i_job        (push_job),
        .o_pop_valid  (pop_valid),
        .i_pop        (pop),
        .o_job        (pop_job)
    );

    // back: signs, arithmetic, output register
    bee_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (pop_valid),
        .o_job_ready    (pop),
        .i_job          (pop_job),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_left_value   (o_left_value),
        .o_operator     (o_operator),
        .o_right_value  (o_right_value),
        .o_result_value (o_result_value)
    );

endmodule

// ===== dv/binary_expression_evaluator_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_expression_evaluator_unit_tb: line evaluator testbench
// Streams text lines into the evaluator one character per transaction. A
// scoreboard parses each accepted character, predicts the result of every
// line, and checks each result transaction field by field. Both sides idle
// at random. One long receiver hold-off fills the line queue, and one sender
// pause drains it.
// ----------------------------------------------------------------------------
module binary_expression_evaluator_unit_tb;

    import bee_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int CHAR_TARGET = 800;
    localparam int IDLE_PCT    = 16;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 100;

    localparam logic [7:0] CH_LF = 8'd10;
    localparam logic [7:0] CH_CR = 8'd13;

    typedef enum logic [3:0] {
        PH_LEAD_A, PH_SIGN_A, PH_DIGIT_A, PH_PRE_OP,
        PH_LEAD_B, PH_SIGN_B, PH_DIGIT_B, PH_TAIL, PH_FAULT
    } t_line_phase;

    typedef struct {
        logic [1:0]          status;
        logic [OUT_BITS-1:0] left;
        logic [1:0]          op;
        logic [OUT_BITS-1:0] right;
        logic [OUT_BITS-1:0] value;
    } t_line_result;

    // Parses accepted characters and holds the results still owed by the block.
    class expr_scoreboard;
        t_line_phase           phase;
        logic [VALUE_BITS-1:0] acc_a, acc_b;
        logic                  neg_a, neg_b;
        logic [1:0]            op_code;
        logic                  quit_cand;
        int                    char_cnt;
        t_line_result          pending_results[$];
        int                    n_checked;
        int                    n_errors;
        int                    n_by_status[4];

        function new();
            n_checked = 0;
            n_errors  = 0;
            foreach (n_by_status[i]) n_by_status[i] = 0;
            clear_line();
        endfunction

        function void clear_line();
            phase     = PH_LEAD_A;
            acc_a     = '0;
            acc_b     = '0;
            neg_a     = 1'b0;
            neg_b     = 1'b0;
            op_code   = OP_ADD;
            quit_cand = 1'b0;
            char_cnt  = 0;
        endfunction

        function bit is_blank(logic [7:0] c);
            return c == CH_SPACE || c == CH_TAB;
        endfunction

        function bit is_numeral(logic [7:0] c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        function bit is_op(logic [7:0] c);
            return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH;
        endfunction

        function logic [1:0] op_of(logic [7:0] c);
            case (c)
                CH_PLUS:  return OP_ADD;
                CH_MINUS: return OP_SUB;
                CH_STAR:  return OP_MUL;
                default:  return OP_DIV;
            endcase
        endfunction

        function logic [VALUE_BITS-1:0] push_digit(logic [VALUE_BITS-1:0] acc, logic [7:0] c);
            logic [VALUE_BITS-1:0] d;
            d = VALUE_BITS'(c - CH_ZERO);
            return acc * VALUE_BITS'(DEC_BASE) + d;
        endfunction

        function void step_phase(logic [7:0] c);
            case (phase)
                PH_LEAD_A, PH_LEAD_B: begin
                    if (!is_blank(c)) begin
                        if (c == CH_PLUS) begin
                            phase = (phase == PH_LEAD_A) ? PH_SIGN_A : PH_SIGN_B;
                        end else if (c == CH_MINUS) begin
                            if (phase == PH_LEAD_A) neg_a = 1'b1;
                            else neg_b = 1'b1;
                            phase = (phase == PH_LEAD_A) ? PH_SIGN_A : PH_SIGN_B;
                        end else if (is_numeral(c)) begin
                            if (phase == PH_LEAD_A) begin
                                acc_a = push_digit(acc_a, c);
                                phase = PH_DIGIT_A;
                            end else begin
                                acc_b = push_digit(acc_b, c);
                                phase = PH_DIGIT_B;
                            end
                        end else begin
                            phase = PH_FAULT;
                        end
                    end
                end
                PH_SIGN_A: begin
                    if (is_numeral(c)) begin
                        acc_a = push_digit(acc_a, c);
                        phase = PH_DIGIT_A;
                    end else begin
                        phase = PH_FAULT;
                    end
                end
                PH_SIGN_B: begin
                    if (is_numeral(c)) begin
                        acc_b = push_digit(acc_b, c);
                        phase = PH_DIGIT_B;
                    end else begin
                        phase = PH_FAULT;
                    end
                end
                PH_DIGIT_A: begin
                    if (is_numeral(c)) acc_a = push_digit(acc_a, c);
                    else if (is_blank(c)) phase = PH_PRE_OP;
                    else if (is_op(c)) begin
                        op_code = op_of(c);
                        phase   = PH_LEAD_B;
                    end else phase = PH_FAULT;
                end
                PH_PRE_OP: begin
                    if (is_op(c)) begin
                        op_code = op_of(c);
                        phase   = PH_LEAD_B;
                    end else if (!is_blank(c)) begin
                        phase = PH_FAULT;
                    end
                end
                PH_DIGIT_B: begin
                    if (is_numeral(c)) acc_b = push_digit(acc_b, c);
                    else if (is_blank(c)) phase = PH_TAIL;
                    else phase = PH_FAULT;
                end
                PH_TAIL: begin
                    if (!is_blank(c)) phase = PH_FAULT;
                end
                default: phase = PH_FAULT;
            endcase
        endfunction

        // Predict the line result once the marked last character is accepted.
        function void note_char(logic [7:0] c, logic last);
            t_line_result                 r;
            logic signed [VALUE_BITS-1:0] a, b, v;
            logic [VALUE_BITS-1:0]        ua, ub, q;
            if (char_cnt == 0) quit_cand = (c == CH_LOW_Q || c == CH_UP_Q);
            if (char_cnt < 2) char_cnt++;
            step_phase(c);
            if (!last) return;
            r = '{status: ST_OK, left: '0, op: OP_ADD, right: '0, value: '0};
            if (char_cnt == 1 && quit_cand) begin
                r.status = ST_QUIT;
            end else if (phase != PH_DIGIT_B && phase != PH_TAIL) begin
                r.status = ST_BAD;
            end else begin
                a = neg_a ? -acc_a : acc_a;
                b = neg_b ? -acc_b : acc_b;
                v = '0;
                case (op_code)
                    OP_ADD: v = a + b;
                    OP_SUB: v = a - b;
                    OP_MUL: v = a * b;
                    default: begin
                        if (b == 0) begin
                            r.status = ST_DIVZ;
                        end else begin
                            // magnitudes, then sign fix: truncation toward zero
                            ua = a[VALUE_BITS-1] ? -a : a;
                            ub = b[VALUE_BITS-1] ? -b : b;
                            q  = ua / ub;
                            v  = (a[VALUE_BITS-1] != b[VALUE_BITS-1]) ? -q : q;
                        end
                    end
                endcase
                r.left  = OUT_BITS'(a);
                r.op    = op_code;
                r.right = OUT_BITS'(b);
                r.value = OUT_BITS'(v);
            end
            pending_results.push_back(r);
            clear_line();
        endfunction

        function void check_result(logic [1:0] st, logic [OUT_BITS-1:0] lv, logic [1:0] opv,
                                   logic [OUT_BITS-1:0] rv, logic [OUT_BITS-1:0] resv);
            t_line_result e;
            if (pending_results.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("ERROR: result with nothing expected: st=%0d l=%0d op=%0d r=%0d v=%0d",
                             st, $signed(lv), opv, $signed(rv), $signed(resv));
                return;
            end
            e = pending_results.pop_front();
            n_checked++;
            n_by_status[e.status]++;
            if (st !== e.status || lv !== e.left || opv !== e.op ||
                rv !== e.right || resv !== e.value) begin
                n_errors++;
                if (n_errors <= 10) begin
                    $display("ERROR: result %0d mismatch", n_checked);
                    $display("  expected st=%0d l=%0d op=%0d r=%0d v=%0d", e.status,
                             $signed(e.left), e.op, $signed(e.right), $signed(e.value));
                    $display("  actual   st=%0d l=%0d op=%0d r=%0d v=%0d", st,
                             $signed(lv), opv, $signed(rv), $signed(resv));
                end
            end
        endfunction

        function void check_leftover();
            if (pending_results.size() != 0) begin
                n_errors++;
                $display("ERROR: %0d expected results never arrived", pending_results.size());
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic                       i_clk;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_ready;
    logic [7:0]                 i_ch    = '0;
    logic                       i_last  = 1'b0;
    logic                       o_valid;
    logic                       i_ready = 1'b0;
    logic [1:0]                 o_status;
    logic signed [OUT_BITS-1:0] o_left_value;
    logic [1:0]                 o_operator;
    logic signed [OUT_BITS-1:0] o_right_value;
    logic signed [OUT_BITS-1:0] o_result_value;

    binary_expression_evaluator_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_ch           (i_ch),
        .i_last         (i_last),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_left_value   (o_left_value),
        .o_operator     (o_operator),
        .o_right_value  (o_right_value),
        .o_result_value (o_result_value)
    );

    expr_scoreboard sb;
    logic [7:0]     line_buf[$];
    int             n_chars = 0;
    int             n_lines = 0;
    int             n_cycles = 0;
    logic           idle_en  = 1'b1;
    logic           hold_req = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // line builders
    // ------------------------------------------------------------------
    function automatic void put_str(string s);
        for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    endfunction

    function automatic void put_blanks(int max_n);
        repeat ($urandom_range(max_n)) line_buf.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
    endfunction

    function automatic void put_sign();
        case ($urandom_range(3))
            0: line_buf.push_back(CH_PLUS);
            1: line_buf.push_back(CH_MINUS);
            default: begin end
        endcase
    endfunction

    // mostly short numbers, some near the 32-bit limits, a few that wrap
    function automatic void put_number();
        string extremes[5] = '{"2147483648", "2147483647", "4294967295",
                               "4294967296", "1000000000"};
        int kind;
        int n;
        kind = $urandom_range(9);
        n    = 0;
        if (kind <= 4) begin
            n = $urandom_range(1, 3);
        end else if (kind == 5) begin
            line_buf.push_back(CH_ZERO);
        end else if (kind <= 7) begin
            line_buf.push_back(8'(CH_ZERO + $urandom_range(1, 4)));
            n = 9;
        end else if (kind == 8) begin
            put_str(extremes[$urandom_range(4)]);
        end else begin
            n = $urandom_range(11, 14);
        end
        repeat (n) line_buf.push_back(8'(CH_ZERO + $urandom_range(9)));
    endfunction

    function automatic void make_good_line();
        logic [7:0] op_chars[4] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
        line_buf.delete();
        if ($urandom_range(29) == 0) begin
            put_str("-2147483648/-1");
            return;
        end
        put_blanks(2);
        put_sign();
        put_number();
        put_blanks(2);
        line_buf.push_back(op_chars[$urandom_range(3)]);
        put_blanks(2);
        put_sign();
        if ($urandom_range(9) == 0) line_buf.push_back(CH_ZERO);
        else put_number();
        put_blanks(2);
    endfunction

    function automatic void make_broken_line();
        int pos;
        make_good_line();
        pos = $urandom_range(line_buf.size() - 1);
        case ($urandom_range(3))
            0: line_buf[pos] = 8'($urandom_range(1, 255));
            1: repeat ($urandom_range(line_buf.size() - 1)) void'(line_buf.pop_back());
            2: line_buf.push_back($urandom_range(1) ? CH_CR : CH_LF);
            default: line_buf.insert(pos, 8'($urandom_range(1, 255)));
        endcase
    endfunction

    function automatic void make_noise_line();
        line_buf.delete();
        repeat ($urandom_range(1, 6)) line_buf.push_back(8'($urandom_range(1, 255)));
    endfunction

    function automatic void make_quit_line();
        line_buf.delete();
        case ($urandom_range(3))
            0: line_buf.push_back(CH_LOW_Q);
            1: line_buf.push_back(CH_UP_Q);
            2: begin
                line_buf.push_back(CH_LOW_Q);
                put_blanks(2);
                line_buf.push_back(CH_UP_Q);
            end
            default: begin
                line_buf.push_back(CH_SPACE);
                line_buf.push_back(CH_UP_Q);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic send_char(logic [7:0] c, logic last);
        while (idle_en && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_ch    <= c;
        i_last  <= last;
        do @(posedge i_clk); while (!o_ready);
        sb.note_char(c, last);
        n_chars++;
    endtask

    task automatic send_line();
        foreach (line_buf[i]) send_char(line_buf[i], i == line_buf.size() - 1);
        n_lines++;
    endtask

    task automatic send_str(string s);
        line_buf.delete();
        put_str(s);
        send_line();
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // result side: check accepted transactions, one long hold-off on request
    initial begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready)
                sb.check_result(o_status, o_left_value, o_operator, o_right_value,
                                o_result_value);
            if (hold_req && !hold_done) begin
                hold_done = 1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= !idle_en || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        while (n_cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            n_cycles++;
        end
        $display("ERROR: timeout after %0d cycles", n_cycles);
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int pick;
        bit paused;
        paused = 0;
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed lines: quit both cases, divide by zero, truncating and
        // signed division, blanks and signs everywhere, short and bad lines
        send_str("q");
        send_str("Q");
        send_str("8/0");
        send_str("-7/2");
        send_str("9*-9");
        send_str("\t+1 - 2 ");
        send_str("1+");
        send_str("x");
        drain();

        while (n_chars < CHAR_TARGET) begin
            pick = $urandom_range(99);
            if (pick < 70) make_good_line();
            else if (pick < 82) make_broken_line();
            else if (pick < 92) make_noise_line();
            else make_quit_line();
            send_line();
            if (!hold_req && n_chars >= 250) hold_req <= 1'b1;
            if (!paused && n_chars >= 450) begin
                paused = 1;
                drain();
            end
            idle_en <= !(n_chars >= 520 && n_chars < 680);
        end
        drain();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        sb.check_leftover();

        $display("Sent %0d lines (%0d characters), checked %0d results", n_lines, n_chars,
                 sb.n_checked);
        $display("Results by status: ok %0d, bad %0d, div-by-zero %0d, quit %0d",
                 sb.n_by_status[ST_OK], sb.n_by_status[ST_BAD], sb.n_by_status[ST_DIVZ],
                 sb.n_by_status[ST_QUIT]);
        if (sb.n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
